// ===== sv/lsst_pkg.sv =====
// Shared types and constants of the light-seeking stepper tracker.
// Used by the stepper phase module and by the tracker core.
`timescale 1ns / 1ps

package lsst_pkg;

  // Width of the step counters; a turn has at most 63 steps.
  localparam int unsigned CNT_W = 6;

  // Register reset values, wide enough for the widest sample.
  localparam logic [15:0] LOWER_RESET = 16'd100;
  localparam logic [15:0] UPPER_RESET = 16'd2000;

  // Configuration address decode.
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_SEL_LOWER = 1'b0;
  localparam logic REG_SEL_UPPER = 1'b1;

  typedef struct packed {
    logic a;
    logic b;
  } coil_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_STEP = 4'b0100,
    ST_SKIP = 4'b1000
  } state_e;

endpackage

// ===== sv/lsst_stepper.sv =====
// Phase and coil state of the two-coil stepper.
// Depends on lsst_pkg for the coil level type.
`timescale 1ns / 1ps

module lsst_stepper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  logic          ccw_i,
  output lsst_pkg::coil_t coils_o
);
  import lsst_pkg::*;

  logic  phase_q, phase_d;
  coil_t coil_q, coil_d;
  logic  toggle_a;

  // A clockwise step toggles coil A from phase one, a counterclockwise step from phase zero.
  assign toggle_a = phase_q ^ ccw_i;

  always_comb begin
    phase_d = phase_q;
    coil_d  = coil_q;
    if (step_en_i) begin
      phase_d = ~phase_q;
      if (toggle_a) begin
        coil_d.a = ~coil_q.a;
      end else begin
        coil_d.b = ~coil_q.b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      coil_q  <= '0;
    end else begin
      phase_q <= phase_d;
      coil_q  <= coil_d;
    end
  end

  assign coils_o = coil_d;

endmodule

// ===== sv/light_seeking_stepper_tracker_core.sv =====
// Light-seeking stepper tracker: search sweep, return to the darkest position, then tracking.
// Depends on lsst_pkg and on lsst_stepper for the coil phase state.
// Flow: accept, then compares on one shared comparator, one operand pair per cycle: left against
// right in track mode, or each sample against both thresholds, then the average against the darkest
// value, in search mode; then up to STEPS_PER_TURN + 1 results as the output side takes them.
// Reset clears all control state and loads the thresholds with 100 and 2000.
`timescale 1ns / 1ps

module light_seeking_stepper_tracker_core #(
  parameter int unsigned STEPS_PER_TURN = 20,
  parameter int unsigned SAMPLE_BITS    = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsst_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        sample_left_i,
  input  logic [SAMPLE_BITS-1:0]        sample_right_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          coil_a_o,
  output logic                          coil_b_o,
  output logic                          stepped_o,
  output logic                          reverse_o,
  output logic                          tracking_o,
  output logic                          last_o
);
  import lsst_pkg::*;

  localparam logic [CNT_W-1:0] STEPS_C = CNT_W'(STEPS_PER_TURN);

  localparam logic [2:0] CMP_L_LO  = 3'd0;
  localparam logic [2:0] CMP_L_HI  = 3'd1;
  localparam logic [2:0] CMP_R_LO  = 3'd2;
  localparam logic [2:0] CMP_R_HI  = 3'd3;
  localparam logic [2:0] CMP_DARK  = 3'd4;
  localparam logic [2:0] CMP_TRACK = 3'd5;

  state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] lower_q, upper_q;
  logic [SAMPLE_BITS-1:0] s_left_q, s_left_d, s_right_q, s_right_d;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic [SAMPLE_BITS-1:0] dark_val_q, dark_val_d;
  logic [SAMPLE_BITS:0]   sum;
  logic [2:0]             cmp_idx_q, cmp_idx_d;
  logic                   track_q, track_d;
  logic [CNT_W-1:0]       count_q, count_d, count_next;
  logic [CNT_W-1:0]       dark_idx_q, dark_idx_d, dark_idx_new;
  logic                   pend_cw_q, pend_cw_d;
  logic [CNT_W-1:0]       back_q, back_d;
  logic                   darker;

  logic [SAMPLE_BITS-1:0] cmp_a, cmp_b;
  logic                   lt;

  logic                   slot_free;
  logic                   load;
  logic                   step_en, step_ccw, res_last;
  coil_t                  coils_nxt;

  logic                   out_valid_q, out_valid_d;
  logic                   coil_a_q, coil_b_q, stepped_q, reverse_q, tracking_q, last_q;

  logic                   cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET[SAMPLE_BITS-1:0];
      upper_q <= UPPER_RESET[SAMPLE_BITS-1:0];
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SEL_LOWER) begin
        lower_q <= pwdata[SAMPLE_BITS-1:0];
      end else begin
        upper_q <= pwdata[SAMPLE_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SEL_UPPER) begin
      prdata = 32'(upper_q);
    end else begin
      prdata = 32'(lower_q);
    end
  end

  // Shared comparator: cmp_a < cmp_b.
  always_comb begin
    unique case (cmp_idx_q)
      CMP_L_LO: begin
        cmp_a = lower_q;
        cmp_b = s_left_q;
      end
      CMP_L_HI: begin
        cmp_a = s_left_q;
        cmp_b = upper_q;
      end
      CMP_R_LO: begin
        cmp_a = lower_q;
        cmp_b = s_right_q;
      end
      CMP_R_HI: begin
        cmp_a = s_right_q;
        cmp_b = upper_q;
      end
      CMP_DARK: begin
        cmp_a = avg_q;
        cmp_b = dark_val_q;
      end
      default: begin
        cmp_a = s_left_q;
        cmp_b = s_right_q;
      end
    endcase
  end

  assign lt = cmp_a < cmp_b;

  assign sum          = {1'b0, sample_left_i} + {1'b0, sample_right_i};
  assign darker       = (count_q == '0) || lt;
  assign count_next   = count_q + 1'b1;
  assign dark_idx_new = darker ? count_q : dark_idx_q;
  assign slot_free    = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == ST_IDLE);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    s_left_d   = s_left_q;
    s_right_d  = s_right_q;
    avg_d      = avg_q;
    cmp_idx_d  = cmp_idx_q;
    track_d    = track_q;
    count_d    = count_q;
    dark_val_d = dark_val_q;
    dark_idx_d = dark_idx_q;
    pend_cw_d  = pend_cw_q;
    back_d     = back_q;
    load       = 1'b0;
    step_en    = 1'b0;
    step_ccw   = 1'b0;
    res_last   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          s_left_d  = sample_left_i;
          s_right_d = sample_right_i;
          avg_d     = sum[SAMPLE_BITS:1];
          cmp_idx_d = track_q ? CMP_TRACK : CMP_L_LO;
          state_d   = ST_CMP;
        end
      end
      ST_CMP: begin
        priority if (cmp_idx_q == CMP_TRACK) begin
          pend_cw_d = lt;
          back_d    = lt ? CNT_W'(0) : CNT_W'(1);
          state_d   = ST_STEP;
        end else if (cmp_idx_q == CMP_DARK) begin
          if (darker) begin
            dark_val_d = avg_q;
            dark_idx_d = count_q;
          end
          pend_cw_d = 1'b1;
          if (count_next >= STEPS_C) begin
            back_d  = STEPS_C - dark_idx_new;
            track_d = 1'b1;
            count_d = '0;
          end else begin
            back_d  = '0;
            count_d = count_next;
          end
          state_d = ST_STEP;
        end else if (lt) begin
          cmp_idx_d = cmp_idx_q + 3'd1;
        end else begin
          state_d = ST_SKIP;
        end
      end
      ST_STEP: begin
        if (slot_free) begin
          load     = 1'b1;
          step_en  = 1'b1;
          step_ccw = !pend_cw_q;
          res_last = pend_cw_q ? (back_q == '0) : (back_q == CNT_W'(1));
          if (pend_cw_q) begin
            pend_cw_d = 1'b0;
          end else begin
            back_d = back_q - 1'b1;
          end
          if (res_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SKIP: begin
        if (slot_free) begin
          load     = 1'b1;
          res_last = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  lsst_stepper u_stepper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .ccw_i     (step_ccw),
    .coils_o   (coils_nxt)
  );

  assign out_valid_d = (out_valid_q && !out_ready_i) || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_idx_q   <= CMP_L_LO;
      track_q     <= 1'b0;
      count_q     <= '0;
      dark_idx_q  <= '0;
      pend_cw_q   <= 1'b0;
      back_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_idx_q   <= cmp_idx_d;
      track_q     <= track_d;
      count_q     <= count_d;
      dark_idx_q  <= dark_idx_d;
      pend_cw_q   <= pend_cw_d;
      back_q      <= back_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_left_q   <= s_left_d;
    s_right_q  <= s_right_d;
    avg_q      <= avg_d;
    dark_val_q <= dark_val_d;
    if (load) begin
      coil_a_q   <= coils_nxt.a;
      coil_b_q   <= coils_nxt.b;
      stepped_q  <= step_en;
      reverse_q  <= step_ccw;
      tracking_q <= track_q;
      last_q     <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign coil_a_o    = coil_a_q;
  assign coil_b_o    = coil_b_q;
  assign stepped_o   = stepped_q;
  assign reverse_o   = reverse_q;
  assign tracking_o  = tracking_q;
  assign last_o      = last_q;

  // A request is worked on alone: no second one is taken in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  // Track mode, once entered, is kept.
  a_track_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    track_q |=> track_q)
    else $error("left track mode");

  // A counterclockwise step is never issued with nothing left to return.
  a_back_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP && !pend_cw_q |-> back_q != '0)
    else $error("return step with empty count");

  // A result without a step is the only result of its request.
  a_skip_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stepped_o |-> last_o && !reverse_o)
    else $error("malformed result without a step");

endmodule
